// ----- rtl/bounded_double_ended_queue_macros.svh -----
// Assertion macros for the bounded double-ended queue.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BDQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdq assertion failed");
// Next-cycle implication.
`define BDQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdq assertion failed");
`else
`define BDQ_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BDQ_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/bdq_pkg.sv -----
// Types and constants shared by the bounded double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

   // Ring depth; a power of two so pointers wrap by truncation.
   localparam int DEPTH = 1024;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [10:0]      CAP_RESET = 11'd1024;

   localparam logic [2:0] MODE_NONE      = 3'd0;
   localparam logic [2:0] MODE_INS_FRONT = 3'd1;
   localparam logic [2:0] MODE_INS_BACK  = 3'd2;
   localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [2:0] MODE_DEL_BACK  = 3'd4;

   localparam logic signed [31:0] EMPTY_WORD = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [31:0] front_value;
      logic signed [31:0] rear_value;
      logic               is_empty;
      logic               is_full;
      logic [10:0]        occupancy;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_FRONT,
      ST_RD_REAR,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/bounded_double_ended_queue.sv -----
// Bounded double-ended queue of signed words kept in a ring buffer memory.
//  - Request channel (req_valid / req_stall / req_data): each request holds a
//    mode (none, insert front, insert back, delete front, delete back) and a
//    word. A request is taken at an edge with req_valid high and req_stall low.
//  - Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response
//    per request: accepted flag, front and rear words after the operation
//    (-1 when empty), empty and full flags and the entry count.
//  - csr_wr_en / csr_wr_data write the capacity (values above 1024 act as
//    1024, zero refuses every insert). Write it only while the queue is idle.
// A new request is taken only in the idle state, after the previous one has
// loaded the response register. The entry memory has a single registered
// read port, so after the pointer/count update and any write, the front and
// the rear words are read one after the other before the response is loaded.
// The response register lets the next request be taken while a response
// waits; if the receiver stalls that register stays full, the next request
// parks in the final state and req_stall stays high until room opens.
// While parked the rear read is repeated so the read data stays put.
// Reset (synchronous, active high) empties the queue, puts the front pointer
// at slot 0 and restores capacity 1024. The memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_double_ended_queue_macros.svh"
module bounded_double_ended_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire bdq_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output bdq_pkg::rsp_type     rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [10:0]     csr_wr_data
);

   // ---------------------------------------------------------------------
   // State registers
   // ---------------------------------------------------------------------
   bdq_pkg::state_type state_ff, state_in;

   logic [bdq_pkg::PTR_W-1:0] front_ptr_ff, front_ptr_in;
   logic [bdq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [10:0]               capacity_ff;
   logic                      ok_ff, ok_in;

   // Entry memory: one write and one registered read per cycle.
   logic signed [31:0] mem [bdq_pkg::DEPTH];
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] front_word_ff;
   logic [bdq_pkg::PTR_W-1:0] rd_addr;
   logic [bdq_pkg::PTR_W-1:0] wr_addr;
   logic                      wr_en;

   logic             rsp_valid_ff;
   bdq_pkg::rsp_type rsp_data_ff;

   logic accept;
   logic load_rsp;

   // ---------------------------------------------------------------------
   // Flags on the current contents
   // ---------------------------------------------------------------------
   logic [bdq_pkg::CNT_W-1:0] eff_cap;
   logic                      full;
   logic                      empty;
   logic [bdq_pkg::PTR_W-1:0] rear_ptr;

   // Capacity saturates at the ring depth.
   assign eff_cap  = (capacity_ff > bdq_pkg::DEPTH_CNT) ? bdq_pkg::DEPTH_CNT
                                                        : capacity_ff;
   assign full     = (count_ff >= eff_cap);
   assign empty    = (count_ff == '0);
   // Rear slot is front + count - 1 modulo depth; a full ring wraps to front-1.
   assign rear_ptr = front_ptr_ff + count_ff[bdq_pkg::PTR_W-1:0] - 1'b1;

   // ---------------------------------------------------------------------
   // Operation decode: pointer/count update and memory write, done at accept
   // ---------------------------------------------------------------------
   always_comb begin
      front_ptr_in = front_ptr_ff;
      count_in     = count_ff;
      ok_in        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = front_ptr_ff + count_ff[bdq_pkg::PTR_W-1:0];
      unique case (req_data.mode)
         bdq_pkg::MODE_INS_FRONT: begin
            if (!full) begin
               front_ptr_in = front_ptr_ff - 1'b1;
               wr_addr      = front_ptr_ff - 1'b1;
               wr_en        = accept;
               count_in     = count_ff + 1'b1;
               ok_in        = 1'b1;
            end
         end
         bdq_pkg::MODE_INS_BACK: begin
            if (!full) begin
               wr_en    = accept;
               count_in = count_ff + 1'b1;
               ok_in    = 1'b1;
            end
         end
         bdq_pkg::MODE_DEL_FRONT: begin
            if (!empty) begin
               front_ptr_in = front_ptr_ff + 1'b1;
               count_in     = count_ff - 1'b1;
               ok_in        = 1'b1;
            end
         end
         bdq_pkg::MODE_DEL_BACK: begin
            if (!empty) begin
               count_in = count_ff - 1'b1;
               ok_in    = 1'b1;
            end
         end
         default: begin
            // none and unused codes leave the queue alone
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bdq_pkg::ST_IDLE:     if (req_valid) state_in = bdq_pkg::ST_RD_FRONT;
         bdq_pkg::ST_RD_FRONT: state_in = bdq_pkg::ST_RD_REAR;
         bdq_pkg::ST_RD_REAR:  state_in = bdq_pkg::ST_RESP;
         bdq_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = bdq_pkg::ST_IDLE;
         end
         default:              state_in = bdq_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      load_rsp  = 1'b0;
      rd_addr   = front_ptr_ff;
      unique case (state_ff)
         bdq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         bdq_pkg::ST_RD_FRONT: rd_addr = front_ptr_ff;
         bdq_pkg::ST_RD_REAR:  rd_addr = rear_ptr;
         bdq_pkg::ST_RESP: begin
            // keep reading the rear slot so a parked response sees the same word
            rd_addr  = rear_ptr;
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Memory
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_data.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::ST_IDLE;
         front_ptr_ff <= '0;
         count_ff     <= '0;
         capacity_ff  <= bdq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            front_ptr_ff <= front_ptr_in;
            count_ff     <= count_in;
         end
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff <= ok_in;
      end
      // front word arrives the cycle the rear read is issued
      if (state_ff == bdq_pkg::ST_RD_REAR) begin
         front_word_ff <= rd_data_ff;
      end
      if (load_rsp) begin
         rsp_data_ff.accepted    <= ok_ff;
         rsp_data_ff.front_value <= empty ? bdq_pkg::EMPTY_WORD : front_word_ff;
         rsp_data_ff.rear_value  <= empty ? bdq_pkg::EMPTY_WORD : rd_data_ff;
         rsp_data_ff.is_empty    <= empty;
         rsp_data_ff.is_full     <= full;
         rsp_data_ff.occupancy   <= 11'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   logic rsp_parked;
   assign rsp_parked = (state_ff == bdq_pkg::ST_RESP) && rsp_valid_ff && rsp_stall;

   `BDQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= bdq_pkg::DEPTH_CNT)
   `BDQ_ASSERT_NXT(a_accept_seq, clock, reset, accept, state_ff == bdq_pkg::ST_RD_FRONT)
   `BDQ_ASSERT_NXT(a_load_valid, clock, reset, load_rsp, rsp_valid_ff)
   `BDQ_ASSERT_NXT(a_park, clock, reset, rsp_parked, state_ff == bdq_pkg::ST_RESP)

endmodule
`default_nettype wire

// ----- bench/bounded_double_ended_queue_test.sv -----
// Self-checking testbench for the bounded double-ended queue: directed table, then random mixes.
`timescale 1ns / 1ps
module bounded_double_ended_queue_test;
   import bdq_pkg::*;

   // 12 ns clock, generous watchdog well above the slowest legal run.
   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_GAP     = 18;
   localparam int LONG_HOLD   = 300;

   // Mode codes 5..7 are not defined; the block must treat them as a no-op.
   localparam logic [2:0] MODE_SPARE5 = 3'd5;
   localparam logic [2:0] MODE_SPARE6 = 3'd6;
   localparam logic [2:0] MODE_SPARE7 = 3'd7;

   // Status words that can be read straight off the spec.
   localparam rsp_type UNTYPED        = '0;
   localparam rsp_type NOTHING_HELD   = '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0};
   localparam rsp_type DONE_EMPTY     = '{1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0, 11'd0};
   localparam rsp_type ZERO_CAP       = '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1, 11'd0};
   localparam rsp_type AFTER_MAX_BACK =
      '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 11'd1};
   localparam rsp_type AFTER_MIN_FRONT =
      '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 11'd2};
   localparam rsp_type SOLE_A_DONE    =
      '{1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b1, 11'd1};
   localparam rsp_type SOLE_A_REFUSED =
      '{1'b0, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b1, 11'd1};

   typedef enum bit {ROW_OP, ROW_CAP} row_kind_type;

   // One line of the directed script: a request, or a capacity write (value holds it).
   typedef struct {
      row_kind_type kind;
      logic [2:0]   mode;
      logic [31:0]  value;
      bit           typed;
      rsp_type      want;
   } plan_row_type;

   plan_row_type plan [31] = '{
      // empty queue after reset: every delete refused, no-op reports empty
      '{ROW_OP,  MODE_NONE,      32'h1234_5678, 1'b1, NOTHING_HELD},
      '{ROW_OP,  MODE_DEL_FRONT, 32'h0000_0000, 1'b1, NOTHING_HELD},
      '{ROW_OP,  MODE_DEL_BACK,  32'hFFFF_FFFF, 1'b1, NOTHING_HELD},
      // extreme words; front insert at slot 0 wraps the pointer to the top
      '{ROW_OP,  MODE_INS_BACK,  32'h7FFF_FFFF, 1'b1, AFTER_MAX_BACK},
      '{ROW_OP,  MODE_INS_FRONT, 32'h8000_0000, 1'b1, AFTER_MIN_FRONT},
      // a stored -1 looks like the empty marker but the flags differ
      '{ROW_OP,  MODE_INS_FRONT, 32'hFFFF_FFFF, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_INS_BACK,  32'h0000_0000, 1'b0, UNTYPED},
      // unused codes act as no-ops
      '{ROW_OP,  MODE_SPARE5,    32'hDEAD_BEEF, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_SPARE6,    32'h0000_0001, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_SPARE7,    32'hFFFF_FFFE, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_BACK,  32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_FRONT, 32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_FRONT, 32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_BACK,  32'h0000_0000, 1'b1, DONE_EMPTY},
      // zero capacity: reports full and empty at once, refuses everything
      '{ROW_CAP, MODE_NONE,      32'd0,         1'b0, UNTYPED},
      '{ROW_OP,  MODE_INS_BACK,  32'h5555_5555, 1'b1, ZERO_CAP},
      '{ROW_OP,  MODE_INS_FRONT, 32'hAAAA_AAAA, 1'b1, ZERO_CAP},
      '{ROW_OP,  MODE_DEL_FRONT, 32'h0000_0000, 1'b1, ZERO_CAP},
      // capacity one: a single insert fills it
      '{ROW_CAP, MODE_NONE,      32'd1,         1'b0, UNTYPED},
      '{ROW_OP,  MODE_INS_FRONT, 32'hAAAA_AAAA, 1'b1, SOLE_A_DONE},
      '{ROW_OP,  MODE_INS_BACK,  32'h5555_5555, 1'b1, SOLE_A_REFUSED},
      // capacity above the ring depth saturates
      '{ROW_CAP, MODE_NONE,      32'd2047,      1'b0, UNTYPED},
      '{ROW_OP,  MODE_INS_BACK,  32'h5555_5555, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_INS_FRONT, 32'h0000_0001, 1'b0, UNTYPED},
      // capacity dropped under the count: entries kept, inserts refused
      '{ROW_CAP, MODE_NONE,      32'd1,         1'b0, UNTYPED},
      '{ROW_OP,  MODE_INS_BACK,  32'h0F0F_0F0F, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_BACK,  32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_FRONT, 32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_FRONT, 32'h0000_0000, 1'b0, UNTYPED},
      '{ROW_OP,  MODE_DEL_BACK,  32'h0000_0000, 1'b1, NOTHING_HELD},
      '{ROW_CAP, MODE_NONE,      32'd1024,      1'b0, UNTYPED}
   };

   // Everything driven to a known value from time zero.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [10:0] csr_wr_data = '0;

   // Predictor state: our own copy of the ring, front pointer, count and capacity.
   logic signed [31:0] ring [DEPTH];
   logic [PTR_W-1:0]   head;
   logic [CNT_W-1:0]   held;
   logic [10:0]        cap_reg;

   rsp_type     status_due [$];   // queue snapshots still owed by the block, oldest first
   int          mismatch_count = 0;
   bit          req_idle_on    = 1'b1;
   bit          rsp_idle_on    = 1'b1;
   int          hold_request   = 0;   // one-shot long stall for the response side
   int unsigned cycle_count    = 0;

   always #(HALF_PERIOD) clock = ~clock;

   bounded_double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Apply one request to the predicted deque and return the status it should report.
   function automatic rsp_type step_deque(req_type r);
      int      lim;
      bit      full;
      bit      empty;
      rsp_type s;
      lim   = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
      full  = int'(held) >= lim;
      empty = (held == '0);
      s     = '0;
      case (r.mode)
         MODE_INS_FRONT: if (!full) begin
            head       = head - 1'b1;   // wraps 0 -> DEPTH-1
            ring[head] = r.value;
            held       = held + 1'b1;
            s.accepted = 1'b1;
         end
         MODE_INS_BACK: if (!full) begin
            ring[PTR_W'(int'(head) + int'(held))] = r.value;
            held       = held + 1'b1;
            s.accepted = 1'b1;
         end
         MODE_DEL_FRONT: if (!empty) begin
            head       = head + 1'b1;
            held       = held - 1'b1;
            s.accepted = 1'b1;
         end
         MODE_DEL_BACK: if (!empty) begin
            held       = held - 1'b1;
            s.accepted = 1'b1;
         end
         default: ;   // none and the spare codes change nothing
      endcase
      if (held == '0) begin
         s.front_value = EMPTY_WORD;
         s.rear_value  = EMPTY_WORD;
      end else begin
         s.front_value = ring[head];
         s.rear_value  = ring[PTR_W'(int'(head) + int'(held) - 1)];
      end
      s.is_empty  = (held == '0);
      s.is_full   = int'(held) >= lim;
      s.occupancy = 11'(held);
      return s;
   endfunction

   function automatic int draw_gap(bit on);
      return on ? int'($urandom_range(0, MAX_GAP)) : 0;
   endfunction

   // Extremes, the -1 lookalike and tiny values show up more often than pure chance.
   function automatic req_type random_request(int ins_pct, int noise_pct);
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
         case ($urandom_range(0, 3))
            0:       r.mode = MODE_NONE;
            1:       r.mode = MODE_SPARE5;
            2:       r.mode = MODE_SPARE6;
            default: r.mode = MODE_SPARE7;
         endcase
      end else if ($urandom_range(0, 99) < ins_pct) begin
         r.mode = $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK;
      end else begin
         r.mode = $urandom_range(0, 1) ? MODE_DEL_FRONT : MODE_DEL_BACK;
      end
      case ($urandom_range(0, 7))
         0:       r.value = 32'h8000_0000;
         1:       r.value = 32'h7FFF_FFFF;
         2:       r.value = EMPTY_WORD;
         3:       r.value = $urandom_range(0, 15);
         default: r.value = $urandom;
      endcase
      return r;
   endfunction

   // Offer one request, hold it until taken, then idle for a random gap.
   // Valid is only dropped when a gap follows, so back-to-back requests keep it high.
   task automatic send_request(req_type r, bit typed, rsp_type want);
      rsp_type predicted;
      int      gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = step_deque(r);
      status_due.push_back(typed ? want : predicted);
      gap = draw_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every owed status; the block is idle afterwards.
   task automatic drain();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [10:0] c);
      drain();
      csr_wr_data <= c;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_reg      = c;
   endtask

   // One random phase: capacity, length, insert share, noise share and idling knobs.
   task automatic run_mix(logic [10:0] c, int n, int ins_pct, int noise_pct,
                          bit req_idle, bit rsp_idle, int hold);
      write_capacity(c);
      req_idle_on  = req_idle;
      rsp_idle_on  = rsp_idle;
      hold_request = hold;
      repeat (n) send_request(random_request(ins_pct, noise_pct), 1'b0, UNTYPED);
   endtask

   // Response side: random stall per status, checks each one against the oldest owed.
   initial begin : status_checker
      int      hold;
      rsp_type got;
      rsp_type want;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            hold         = hold_request;   // long stall so the block backs up
            hold_request = 0;
         end else begin
            hold = draw_gap(rsp_idle_on);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         got = rsp_data;
         if (status_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] status with no request owed: acc=%0b front=%0d rear=%0d",
                        $realtime, got.accepted, got.front_value, got.rear_value);
         end else begin
            want = status_due.pop_front();
            if (got.accepted !== want.accepted || got.front_value !== want.front_value ||
                got.rear_value !== want.rear_value || got.is_empty !== want.is_empty ||
                got.is_full !== want.is_full || got.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("[%0t] status mismatch", $realtime);
                  $display("   want acc=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                           want.accepted, want.front_value, want.rear_value,
                           want.is_empty, want.is_full, want.occupancy);
                  $display("   got  acc=%0b front=%0d rear=%0d empty=%0b full=%0b count=%0d",
                           got.accepted, got.front_value, got.rear_value,
                           got.is_empty, got.is_full, got.occupancy);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      req_type r;
      head    = '0;
      held    = '0;
      cap_reg = CAP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed script with random idling on both sides.
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CAP) begin
            write_capacity(plan[i].value[10:0]);
         end else begin
            r.mode  = plan[i].mode;
            r.value = plan[i].value;
            send_request(r, plan[i].typed, plan[i].want);
         end
      end

      // Random mixes. Mostly small capacities so full and empty are hit often.
      run_mix(11'd8,    120, 55, 8,  1'b1, 1'b1, 0);
      run_mix(11'd1,    60,  50, 8,  1'b1, 1'b1, 0);
      // requests keep coming while the response side sits on a long stall
      run_mix(11'd16,   80,  60, 8,  1'b0, 1'b1, LONG_HOLD);
      run_mix(11'd2,    60,  50, 8,  1'b0, 1'b0, 0);
      run_mix(11'd0,    20,  60, 20, 1'b1, 1'b1, 0);
      run_mix(11'd32,   60,  85, 8,  1'b1, 1'b0, 0);
      // capacity drops below what is held; only deletes get through until it fits
      run_mix(11'd4,    60,  40, 8,  1'b0, 1'b1, 0);
      run_mix(11'd5,    80,  50, 8,  1'b1, 1'b1, 0);
      run_mix(11'd1024, 80,  55, 8,  1'b1, 1'b1, 0);
      // saturated capacity behaves as the full ring depth
      run_mix(11'd2047, 60,  70, 8,  1'b0, 1'b0, 0);
      run_mix(11'd1024, 60,  30, 8,  1'b1, 1'b1, 0);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- bounded_double_ended_queue.f -----
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bounded_double_ended_queue.sv
bench/bounded_double_ended_queue_test.sv
